@@ rtl/aging_message_slot_table_macros.svh @@
// assertion macros for the aging message slot table
// no dependencies; taken in by the modules that carry assertions
`ifndef AGING_MESSAGE_SLOT_TABLE_MACROS_SVH
`define AGING_MESSAGE_SLOT_TABLE_MACROS_SVH

// property holds whenever reset is low
`define AMST_ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define AMST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/amst_pkg.sv @@
// types and constants for the aging message slot table
// no dependencies; used by amst_cmp_unit and aging_message_slot_table
package amst_pkg;

   localparam int SLOT_COUNT = 10;
   localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CNT_W = $clog2(SLOT_COUNT + 1);
   localparam int LIMIT_W = 18;
   localparam int CSR_ADDR_W = 3;

   localparam logic [LIMIT_W-1:0] MS_PER_SECOND = LIMIT_W'(1000);
   localparam logic [7:0] HOLD_RESET = 8'd5;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(5000);
   localparam logic [CNT_W-1:0] SLOT_FULL = CNT_W'(SLOT_COUNT);

   typedef enum logic [0:0] {
      REQ_POST  = 1'b0,
      REQ_SWEEP = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      STAT_STORED    = 2'd0,
      STAT_REFRESHED = 2'd1,
      STAT_DROPPED   = 2'd2,
      STAT_SWEPT     = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_POST_SCAN,
      ST_SWEEP_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      req_kind_type req_type;
      logic [7:0]   message_id;
      logic [31:0]  now_ms;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [3:0]  active_count;
      logic [7:0]  head_message;
      logic        sweep_needed;
   } rsp_type;

   typedef struct packed {
      logic id_match;
      logic expired;
   } cmp_type;

endpackage

@@ rtl/amst_cmp_unit.sv @@
// shared slot compare unit: id match and wrapping age against hold limit
// depends on amst_pkg
module amst_cmp_unit (
   input  logic [7:0]                  slot_msg,
   input  logic [31:0]                 slot_time,
   input  logic [7:0]                  req_id,
   input  logic [31:0]                 now_ms,
   input  logic [amst_pkg::LIMIT_W-1:0] limit,
   output amst_pkg::cmp_type           cmp
);

   logic [31:0] age;

   assign age = now_ms - slot_time;

   always_comb begin
      cmp.id_match = (slot_msg == req_id);
      cmp.expired  = (age > 32'(limit));
   end

endmodule

@@ rtl/aging_message_slot_table.sv @@
// aging message slot table top level: sequencer, slot storage, apb register
// depends on amst_pkg, amst_cmp_unit and aging_message_slot_table_macros.svh
//
// A transfer is taken when start is high and busy is low. A post or a sweep
// walks the occupied slots one per cycle through a single compare unit; a post
// that hits its id early, or a post of id zero, finishes sooner. The result
// shows on rsp_data for exactly one cycle with rsp_valid high, in the cycle busy
// falls; the receiver cannot stall it and must capture it then. Occupied
// slots always sit at the bottom of the table, so no clearing pass is needed.
`include "aging_message_slot_table_macros.svh"

module aging_message_slot_table (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  amst_pkg::req_type               req_data,
   output logic                            rsp_valid,
   output amst_pkg::rsp_type               rsp_data,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [amst_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);

   amst_pkg::state_type state_ff, state_in;
   amst_pkg::req_type req_ff, req_in;
   amst_pkg::status_type status_ff, status_in;
   amst_pkg::rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [amst_pkg::CNT_W-1:0] idx_ff, idx_in;
   logic [amst_pkg::CNT_W-1:0] dst_ff, dst_in;
   logic [amst_pkg::CNT_W-1:0] count_ff, count_in;
   logic [7:0] hold_ff;
   logic [amst_pkg::LIMIT_W-1:0] limit_ff;

   logic [7:0]  msg_mem  [amst_pkg::SLOT_COUNT];
   logic [31:0] time_mem [amst_pkg::SLOT_COUNT];

   logic wr_en;
   logic [amst_pkg::IDX_W-1:0] wr_idx;
   logic [7:0] wr_msg;
   logic [31:0] wr_time;
   logic [7:0] rd_msg_ff;
   logic [31:0] rd_time_ff;
   logic [7:0] head_ff;
   logic at_end;
   logic csr_write;
   amst_pkg::cmp_type cmp;

   // configuration register
   assign pready = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign prdata = (paddr[amst_pkg::CSR_ADDR_W-1] == 1'b0) ? {24'd0, hold_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff  <= amst_pkg::HOLD_RESET;
         limit_ff <= amst_pkg::LIMIT_RESET;
      end else if (csr_write && (paddr[amst_pkg::CSR_ADDR_W-1] == 1'b0)) begin
         hold_ff  <= pwdata[7:0];
         limit_ff <= amst_pkg::LIMIT_W'(pwdata[7:0]) * amst_pkg::MS_PER_SECOND;
      end
   end

   // slot storage
   assign at_end  = (idx_ff == count_ff);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         msg_mem[wr_idx]  <= wr_msg;
         time_mem[wr_idx] <= wr_time;
      end
      rd_msg_ff  <= msg_mem[idx_in[amst_pkg::IDX_W-1:0]];
      rd_time_ff <= time_mem[idx_in[amst_pkg::IDX_W-1:0]];
   end

   // copy of slot 0 for the head id
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= 8'd0;
      end else if (wr_en && (wr_idx == '0)) begin
         head_ff <= wr_msg;
      end
   end

   amst_cmp_unit u_cmp (
      .slot_msg  (rd_msg_ff),
      .slot_time (rd_time_ff),
      .req_id    (req_ff.message_id),
      .now_ms    (req_ff.now_ms),
      .limit     (limit_ff),
      .cmp       (cmp)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         amst_pkg::ST_IDLE: begin
            if (start) begin
               if (req_data.req_type == amst_pkg::REQ_SWEEP) begin
                  state_in = amst_pkg::ST_SWEEP_SCAN;
               end else if (req_data.message_id == 8'd0) begin
                  state_in = amst_pkg::ST_FINISH;
               end else begin
                  state_in = amst_pkg::ST_POST_SCAN;
               end
            end
         end
         amst_pkg::ST_POST_SCAN: begin
            if (at_end || cmp.id_match) begin
               state_in = amst_pkg::ST_FINISH;
            end
         end
         amst_pkg::ST_SWEEP_SCAN: begin
            if (at_end) begin
               state_in = amst_pkg::ST_FINISH;
            end
         end
         amst_pkg::ST_FINISH: begin
            state_in = amst_pkg::ST_IDLE;
         end
         default: begin
            state_in = amst_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath control
   always_comb begin
      req_in       = req_ff;
      status_in    = status_ff;
      idx_in       = idx_ff;
      dst_in       = dst_ff;
      count_in     = count_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      wr_en        = 1'b0;
      wr_idx       = idx_ff[amst_pkg::IDX_W-1:0];
      wr_msg       = rd_msg_ff;
      wr_time      = rd_time_ff;
      unique case (state_ff)
         amst_pkg::ST_IDLE: begin
            if (start) begin
               req_in    = req_data;
               idx_in    = '0;
               dst_in    = '0;
               status_in = (req_data.req_type == amst_pkg::REQ_SWEEP) ?
                           amst_pkg::STAT_SWEPT : amst_pkg::STAT_DROPPED;
            end
         end
         amst_pkg::ST_POST_SCAN: begin
            if (at_end) begin
               if (count_ff < amst_pkg::SLOT_FULL) begin
                  wr_en     = 1'b1;
                  wr_idx    = count_ff[amst_pkg::IDX_W-1:0];
                  wr_msg    = req_ff.message_id;
                  wr_time   = req_ff.now_ms;
                  count_in  = amst_pkg::CNT_W'(count_ff + 1'b1);
                  status_in = amst_pkg::STAT_STORED;
               end else begin
                  status_in = amst_pkg::STAT_DROPPED;
               end
            end else if (cmp.id_match) begin
               wr_en     = 1'b1;
               wr_time   = req_ff.now_ms;
               status_in = amst_pkg::STAT_REFRESHED;
            end else begin
               idx_in = amst_pkg::CNT_W'(idx_ff + 1'b1);
            end
         end
         amst_pkg::ST_SWEEP_SCAN: begin
            if (at_end) begin
               count_in = dst_ff;
            end else begin
               if (!cmp.expired) begin
                  wr_en  = 1'b1;
                  wr_idx = dst_ff[amst_pkg::IDX_W-1:0];
                  dst_in = amst_pkg::CNT_W'(dst_ff + 1'b1);
               end
               idx_in = amst_pkg::CNT_W'(idx_ff + 1'b1);
            end
         end
         amst_pkg::ST_FINISH: begin
            rsp_valid_in        = 1'b1;
            rsp_in.status       = status_ff;
            rsp_in.active_count = 4'(count_ff);
            rsp_in.head_message = (count_ff != '0) ? head_ff : 8'd0;
            rsp_in.sweep_needed = (count_ff != '0);
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= amst_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      status_ff <= status_in;
      idx_ff    <= idx_in;
      dst_ff    <= dst_in;
      rsp_ff    <= rsp_in;
   end

   assign busy      = (state_ff != amst_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `AMST_ASSERT_ALWAYS(a_count_bound, clock, reset,
      count_ff <= amst_pkg::SLOT_FULL, "slot count above table size")
   `AMST_ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy,
      "transfer taken but block not busy")
   `AMST_ASSERT_NEXT(a_rsp_pulse, clock, reset, rsp_valid, !rsp_valid,
      "result strobe longer than one cycle")
   `AMST_ASSERT_ALWAYS(a_rsp_idle, clock, reset, !rsp_valid || !busy,
      "result shown while busy")
   `AMST_ASSERT_ALWAYS(a_sweep_dst, clock, reset,
      (state_ff != amst_pkg::ST_SWEEP_SCAN) || (dst_ff <= idx_ff),
      "sweep write index passed read index")

endmodule
